// ===== sv/echo_pulse_ranging_macros.svh =====
// Assertion macros for the echo ranging block.
`ifndef ECHO_PULSE_RANGING_MACROS_SVH
`define ECHO_PULSE_RANGING_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define EPR_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define EPR_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ===== sv/epr_pkg.sv =====
// Shared types and codes for the echo ranging block.
package epr_pkg;

    // Request codes of the input item
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_EDGE  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_VELOCITY = 2'd0;
    localparam logic [1:0] CFG_MAX_DIST = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT  = 2'd2;

    // Stamp store write strobes
    typedef struct packed {
        logic rise_we;
        logic fall_we;
    } t_wr;

    // Measurement finished on the accepted item
    typedef struct packed {
        logic       valid;
        logic       timed;
        logic [1:0] ch;
    } t_fin;

endpackage

// ===== sv/epr_stamp_mem.sv =====
// Per-channel rise and fall stamp store, registered read.
module epr_stamp_mem #(
    parameter int NUM_CHANNELS = 4,
    parameter int COUNTER_BITS = 16,
    parameter int AW           = 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_rd_en,
    input  logic [AW-1:0]           i_addr,
    input  epr_pkg::t_wr            i_wr,
    input  logic [COUNTER_BITS-1:0] i_data,
    output logic [COUNTER_BITS-1:0] o_rise,
    output logic [COUNTER_BITS-1:0] o_fall
);
    import epr_pkg::*;

    logic [COUNTER_BITS-1:0] r_rise_mem [NUM_CHANNELS];
    logic [COUNTER_BITS-1:0] r_fall_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_rise_vld;
    logic [NUM_CHANNELS-1:0] r_fall_vld;
    logic [COUNTER_BITS-1:0] r_rise_q;
    logic [COUNTER_BITS-1:0] r_fall_q;

    // never-written entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_vld <= '0;
            r_fall_vld <= '0;
        end else begin
            if (i_wr.rise_we) begin
                r_rise_vld[i_addr] <= 1'b1;
            end
            if (i_wr.fall_we) begin
                r_fall_vld[i_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.rise_we) begin
            r_rise_mem[i_addr] <= i_data;
        end
        if (i_wr.fall_we) begin
            r_fall_mem[i_addr] <= i_data;
        end
        if (i_rd_en) begin
            r_rise_q <= r_rise_vld[i_addr] ? r_rise_mem[i_addr] : '0;
            r_fall_q <= r_fall_vld[i_addr] ? r_fall_mem[i_addr] : '0;
        end
    end

    assign o_rise = r_rise_q;
    assign o_fall = r_fall_q;

endmodule

// ===== sv/epr_ctrl.sv =====
// Measurement control: busy, active channel, edge phase and timeout count.
module epr_ctrl #(
    parameter int NUM_CHANNELS = 4,
    parameter int AW           = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [1:0]    i_req_type,
    input  logic [1:0]    i_channel,
    input  logic [7:0]    i_timeout,
    output logic [AW-1:0] o_addr,
    output epr_pkg::t_wr  o_wr,
    output epr_pkg::t_fin o_fin
);
    import epr_pkg::*;

    logic       r_busy;
    logic [1:0] r_act;
    logic       r_phase;
    logic [7:0] r_wait;
    logic       n_busy;
    logic [1:0] n_act;
    logic       n_phase;
    logic [7:0] n_wait;
    logic [7:0] w_wait_inc;
    logic       w_ch_ok;
    logic       w_edge_hit;

    assign w_wait_inc = r_wait + 8'd1;
    assign w_ch_ok    = 32'(i_channel) < NUM_CHANNELS;
    assign w_edge_hit = r_busy && (i_channel == r_act) && w_ch_ok;

    // edges address their own channel, ticks the active one
    assign o_addr = (i_req_type == REQ_EDGE) ? AW'(i_channel) : AW'(r_act);

    always_comb begin
        n_busy  = r_busy;
        n_act   = r_act;
        n_phase = r_phase;
        n_wait  = r_wait;
        o_wr    = '0;
        o_fin   = '0;
        o_fin.ch = r_act;
        if (i_accept) begin
            case (i_req_type)
                REQ_START: begin
                    if (!r_busy && w_ch_ok) begin
                        n_busy  = 1'b1;
                        n_act   = i_channel;
                        n_phase = 1'b0;
                        n_wait  = '0;
                    end
                end
                REQ_EDGE: begin
                    if (w_edge_hit) begin
                        if (!r_phase) begin
                            o_wr.rise_we = 1'b1;
                            n_phase      = 1'b1;
                        end else begin
                            o_wr.fall_we = 1'b1;
                            o_fin.valid  = 1'b1;
                            n_busy       = 1'b0;
                            n_phase      = 1'b0;
                            n_wait       = '0;
                        end
                    end
                end
                REQ_TICK: begin
                    if (r_busy) begin
                        if (w_wait_inc >= i_timeout) begin
                            o_fin.valid = 1'b1;
                            o_fin.timed = 1'b1;
                            n_busy      = 1'b0;
                            n_phase     = 1'b0;
                            n_wait      = '0;
                        end else begin
                            n_wait = w_wait_inc;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_act   <= '0;
            r_phase <= 1'b0;
            r_wait  <= '0;
        end else begin
            r_busy  <= n_busy;
            r_act   <= n_act;
            r_phase <= n_phase;
            r_wait  <= n_wait;
        end
    end

endmodule

// ===== sv/epr_scale.sv =====
// Result pipeline: echo width, velocity multiply, clamp and output register.
module epr_scale #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  epr_pkg::t_fin           i_fin,
    input  logic [COUNTER_BITS-1:0] i_stamp,
    input  logic [COUNTER_BITS-1:0] i_rise,
    input  logic [COUNTER_BITS-1:0] i_fall,
    input  logic [15:0]             i_velocity,
    input  logic [15:0]             i_max_dist,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [1:0]              o_out_channel,
    output logic [15:0]             o_distance,
    output logic                    o_timed_out
);
    import epr_pkg::*;

    localparam int PW = COUNTER_BITS + 16;
    localparam int DW = PW - 17;
    localparam int CW = (DW > 16) ? DW : 16;

    // stage 1: finished item, stamps arrive from the store
    logic                    r_s1_vld;
    logic [1:0]              r_s1_ch;
    logic                    r_s1_timed;
    logic [COUNTER_BITS-1:0] r_s1_stamp;
    // stage 2: width
    logic                    r_s2_vld;
    logic [1:0]              r_s2_ch;
    logic                    r_s2_timed;
    logic [COUNTER_BITS-1:0] r_s2_width;
    // stage 3: product
    logic                    r_s3_vld;
    logic [1:0]              r_s3_ch;
    logic                    r_s3_timed;
    logic [PW-1:0]           r_s3_prod;
    // output
    logic                    r_o_vld;
    logic [1:0]              r_o_ch;
    logic                    r_o_timed;
    logic [15:0]             r_o_dist;

    logic                    w_m1;
    logic                    w_m2;
    logic                    w_m3;
    logic [COUNTER_BITS-1:0] w_fall;
    logic [COUNTER_BITS-1:0] w_width;
    logic [CW-1:0]           w_dist;
    logic [CW-1:0]           w_max;

    assign w_m3 = !r_o_vld || i_out_ready;
    assign w_m2 = !r_s3_vld || w_m3;
    assign w_m1 = !r_s2_vld || w_m2;
    assign o_in_ready = !r_s1_vld || w_m1;

    // fall edge ends: fall stamp is the item's own stamp
    assign w_fall  = r_s1_timed ? i_fall : r_s1_stamp;
    // wrap case: CMAX - rise + fall == ~rise + fall, never overflows
    assign w_width = (w_fall > i_rise) ? (w_fall - i_rise) : (~i_rise + w_fall);

    assign w_dist = CW'(r_s3_prod[PW-1:17]);
    assign w_max  = CW'(i_max_dist);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_vld <= i_fin.valid;
            end
            if (w_m1) begin
                r_s2_vld <= r_s1_vld;
            end
            if (w_m2) begin
                r_s3_vld <= r_s2_vld;
            end
            if (w_m3) begin
                r_o_vld <= r_s3_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_fin.valid) begin
            r_s1_ch    <= i_fin.ch;
            r_s1_timed <= i_fin.timed;
            r_s1_stamp <= i_stamp;
        end
        if (w_m1 && r_s1_vld) begin
            r_s2_ch    <= r_s1_ch;
            r_s2_timed <= r_s1_timed;
            r_s2_width <= w_width;
        end
        if (w_m2 && r_s2_vld) begin
            r_s3_ch    <= r_s2_ch;
            r_s3_timed <= r_s2_timed;
            r_s3_prod  <= PW'(r_s2_width) * PW'(i_velocity);
        end
        if (w_m3 && r_s3_vld) begin
            r_o_ch    <= r_s3_ch;
            r_o_timed <= r_s3_timed;
            r_o_dist  <= (w_dist > w_max) ? i_max_dist : 16'(w_dist);
        end
    end

    assign o_out_valid   = r_o_vld;
    assign o_out_channel = r_o_ch;
    assign o_distance    = r_o_dist;
    assign o_timed_out   = r_o_timed;

endmodule

// ===== sv/echo_pulse_ranging.sv =====
// Top level of the multi-channel echo pulse-width ranging block.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------
//  in       | i_in_valid / o_in_ready    | i_req_type, i_channel, i_stamp
//  out      | o_out_valid / i_out_ready  | o_out_channel, o_distance, o_timed_out
//  cfg      | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
//  One item per cycle while o_in_ready is high. A finishing item's result goes
//  through the stamp store read on the accepting edge, then width, multiply, clamp.
//  Control state updates on the accepting edge, so the next item sees it at once.
//  Reset is synchronous; stamps read as zero until written (per-entry valid
//  bits), no clearing pass. o_in_ready drops only when all four result
//  stages are full and the output item is stalled.
module echo_pulse_ranging #(
    parameter int NUM_CHANNELS = 4,
    parameter int COUNTER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [1:0]  i_channel,
    input  logic [15:0] i_stamp,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_out_channel,
    output logic [15:0] o_distance,
    output logic        o_timed_out,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import epr_pkg::*;

    `include "echo_pulse_ranging_macros.svh"

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // configuration registers
    logic [15:0] r_velocity;
    logic [15:0] r_max_dist;
    logic [7:0]  r_timeout;

    logic                    w_accept;
    logic [AW-1:0]           w_addr;
    t_wr                     w_wr;
    t_fin                    w_fin;
    logic [COUNTER_BITS-1:0] w_stamp;
    logic [COUNTER_BITS-1:0] w_rise;
    logic [COUNTER_BITS-1:0] w_fall;

    assign w_accept = i_in_valid && o_in_ready;
    // stamp kept to the counter width (zero-extended when the counter is wider)
    assign w_stamp  = COUNTER_BITS'(i_stamp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_velocity <= 16'd2248;
            r_max_dist <= 16'd400;
            r_timeout  <= 8'd50;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VELOCITY: r_velocity <= i_cfg_data;
                CFG_MAX_DIST: r_max_dist <= i_cfg_data;
                CFG_TIMEOUT:  r_timeout  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    epr_ctrl #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .AW          (AW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_req_type(i_req_type),
        .i_channel (i_channel),
        .i_timeout (r_timeout),
        .o_addr    (w_addr),
        .o_wr      (w_wr),
        .o_fin     (w_fin)
    );

    // stamps written and read on the accepting edge; a fall-edge finish
    // uses its own stamp, so the same-edge write needs no bypass
    epr_stamp_mem #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .COUNTER_BITS(COUNTER_BITS),
        .AW          (AW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rd_en(w_accept),
        .i_addr (w_addr),
        .i_wr   (w_wr),
        .i_data (w_stamp),
        .o_rise (w_rise),
        .o_fall (w_fall)
    );

    epr_scale #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fin        (w_fin),
        .i_stamp      (w_stamp),
        .i_rise       (w_rise),
        .i_fall       (w_fall),
        .i_velocity   (r_velocity),
        .i_max_dist   (r_max_dist),
        .o_in_ready   (o_in_ready),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_channel(o_out_channel),
        .o_distance   (o_distance),
        .o_timed_out  (o_timed_out)
    );

    `EPR_ASSERT_IMP(a_fin_on_accept, i_clk, i_rst_n, w_fin.valid, w_accept,
        "measurement finished without an accepted item")
    `EPR_ASSERT_IMP(a_wr_on_accept, i_clk, i_rst_n, w_wr.rise_we || w_wr.fall_we, w_accept,
        "stamp store written without an accepted item")
    `EPR_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !o_in_ready,
        o_out_valid && !i_out_ready, "input stalled while output is free")
    `EPR_ASSERT_NEXT(a_idle_after_fin, i_clk, i_rst_n, w_fin.valid,
        !u_ctrl.r_busy, "still busy after a finished measurement")

endmodule
